// ----- hdl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared types, constants and register indexes for the escape-time engine.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // Fixed-point and sizing constants
    localparam int IMAGE_SIZE      = 1024;
    localparam int COORD_FRAC_BITS = 24;
    localparam int ITER_BITS       = 16;
    localparam int MUL_W           = 32;
    localparam int NORM_BITS       = 17;
    localparam int STEP_W          = 31;
    localparam int LIMIT_W         = 63;
    localparam int SIZE_W          = 11;
    localparam int PIX_W           = 10;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 64;

    // Register reset values
    localparam logic [STEP_W-1:0]  STEP_RESET     = 31'd24576;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 63'd2533274790395904;
    localparam int                 MAX_ITER_RESET = 1000;
    localparam logic [SIZE_W-1:0]  SIZE_RESET     = SIZE_W'(IMAGE_SIZE);

    // Square saturation
    localparam logic [63:0] SQ_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SQRT_SQ_MAX = 64'd3037000499;

    // Normalized value of one whole (count equal to the maximum)
    localparam logic [NORM_BITS-1:0] NORM_ONE = 17'h10000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COORD_STEP   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE   = 8'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_row;
        logic [PIX_W-1:0] pixel_col;
    } t_pixel_req;

    typedef struct packed {
        logic [PIX_W-1:0]     out_row;
        logic [PIX_W-1:0]     out_col;
        logic [15:0]          iteration_count;
        logic [NORM_BITS-1:0] normalized_value;
        logic                 inside_set;
    } t_pixel_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INITX,
        S_INITY,
        S_INITW,
        S_SQX,
        S_SQY,
        S_XY,
        S_TEST,
        S_UPD,
        S_DIV,
        S_HOLD
    } t_state;

endpackage

// ----- hdl/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel engine
// One request at a time; the next is taken once the result is in the output
// register, so the engine takes no new pixel while one is in flight.
// Synchronous active-low reset returns the configuration registers to their
// defaults and clears the sequencer state and the output valid flag.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
    parameter int ITER_BITS = mbe_pkg::ITER_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Pixel requests
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mbe_pkg::t_pixel_req               i_in_data,
    // Results
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mbe_pkg::t_pixel_rsp               o_out_data,
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mbe_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the user must issue
    // them only while the engine is idle, as the block does not enforce it.
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]    r_step;
    logic [LIMIT_W-1:0]   r_limit;
    logic [ITER_BITS-1:0] r_max_iter;
    logic [SIZE_W-1:0]    r_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= STEP_RESET;
            r_limit    <= LIMIT_RESET;
            r_max_iter <= ITER_BITS'(MAX_ITER_RESET);
            r_size     <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COORD_STEP:   r_step     <= i_cfg_data[STEP_W-1:0];
                CFG_ESCAPE_LIMIT: r_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_MAX_ITER:     r_max_iter <= i_cfg_data[ITER_BITS-1:0];
                CFG_IMAGE_SIZE:   r_size     <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath state. Coordinates are signed fixed point with
    // COORD_FRAC_BITS fraction bits; the squares carry twice that.
    // ------------------------------------------------------------------
    t_state               r_state;
    t_state               n_state;
    t_pixel_req           r_req;
    logic                 r_neg;
    logic signed [63:0]   r_x0;
    logic signed [63:0]   r_y0;
    logic signed [63:0]   r_x;
    logic signed [63:0]   r_y;
    logic signed [63:0]   r_xy;
    logic [63:0]          r_x2;
    logic [63:0]          r_y2;
    logic [ITER_BITS-1:0] r_count;
    logic                 r_esc;
    logic [NORM_BITS-1:0] r_norm;
    logic                 r_out_valid;
    t_pixel_rsp           r_out;

    // Shared multiplier and divider hookup
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [2*MUL_W-1:0]   mul_p;
    logic                 div_start;
    logic                 div_done;
    logic [NORM_BITS-1:0] div_quot;

    mbe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    mbe_div #(
        .ITER_BITS (ITER_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_count (r_count),
        .i_max   (r_max_iter),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Pixel offset from the image center: 2*index - size, in half pixels.
    logic [PIX_W-1:0]    coord;
    logic signed [11:0]  coord_off;
    logic [11:0]         coord_mag;

    assign coord     = (r_state == S_INITX) ? r_req.pixel_col : r_req.pixel_row;
    assign coord_off = $signed({1'b0, coord, 1'b0}) - $signed({1'b0, r_size});
    assign coord_mag = coord_off[11] ? 12'(-coord_off) : 12'(coord_off);

    // Magnitudes feed the unsigned multiplier. A magnitude above the square
    // root of the largest square saturates that square, and such a pixel
    // escapes at once, so the truncated operand is never used to update.
    logic [63:0] x_mag;
    logic [63:0] y_mag;
    logic        x_sat;
    logic        y_sat;

    assign x_mag = r_x[63] ? (64'd0 - r_x) : r_x;
    assign y_mag = r_y[63] ? (64'd0 - r_y) : r_y;
    assign x_sat = (x_mag > SQRT_SQ_MAX);
    assign y_sat = (y_mag > SQRT_SQ_MAX);

    // Signed product for the scaled start point and the cross term.
    logic signed [63:0] init_val;
    assign init_val = r_neg ? $signed(64'd0 - mul_p) : $signed(mul_p);

    // Escape test: the unsaturated sum of two squares compares the same way
    // against a limit that is itself below 2^63.
    logic [64:0] sq_sum;
    logic        esc;
    logic        finish;

    assign sq_sum = {1'b0, r_x2} + {1'b0, r_y2};
    assign esc    = (sq_sum >= {2'b00, r_limit});
    assign finish = esc || (r_count >= r_max_iter);

    // Next coordinates, each an arithmetic shift that rounds toward minus
    // infinity followed by the start point.
    logic signed [63:0] sq_diff;
    logic signed [63:0] next_x;
    logic signed [63:0] next_y;

    assign sq_diff = $signed(r_x2 - r_y2);
    assign next_x  = (sq_diff >>> COORD_FRAC_BITS) + r_x0;
    assign next_y  = (r_xy >>> (COORD_FRAC_BITS - 1)) + r_y0;

    // The output register is free when empty or being emptied this cycle.
    logic out_free;
    logic out_load;

    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = (r_state == S_HOLD) && out_free;

    // ------------------------------------------------------------------
    // Sequencer. Each iteration issues x*x, y*y and |x|*|y| to the shared
    // multiplier, tests for escape, then forms the new point.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_INITX;
                end
            end
            S_INITX: begin
                mul_a   = MUL_W'(coord_mag);
                mul_b   = MUL_W'(r_step);
                n_state = S_INITY;
            end
            S_INITY: begin
                mul_a   = MUL_W'(coord_mag);
                mul_b   = MUL_W'(r_step);
                n_state = S_INITW;
            end
            S_INITW: begin
                n_state = S_SQX;
            end
            S_SQX: begin
                mul_a   = x_mag[MUL_W-1:0];
                mul_b   = x_mag[MUL_W-1:0];
                n_state = S_SQY;
            end
            S_SQY: begin
                mul_a   = y_mag[MUL_W-1:0];
                mul_b   = y_mag[MUL_W-1:0];
                n_state = S_XY;
            end
            S_XY: begin
                mul_a   = x_mag[MUL_W-1:0];
                mul_b   = y_mag[MUL_W-1:0];
                n_state = S_TEST;
            end
            S_TEST: begin
                if (finish) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_SQX;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_req <= i_in_data;
                end
            end
            S_INITX: begin
                r_neg <= coord_off[11];
            end
            S_INITY: begin
                r_neg <= coord_off[11];
                r_x0  <= init_val;
                r_x   <= init_val;
            end
            S_INITW: begin
                r_y0    <= init_val;
                r_y     <= init_val;
                r_count <= '0;
            end
            S_SQX: begin
                r_neg <= r_x[63] ^ r_y[63];
            end
            S_SQY: begin
                r_x2 <= x_sat ? SQ_MAX : mul_p;
            end
            S_XY: begin
                r_y2 <= y_sat ? SQ_MAX : mul_p;
            end
            S_TEST: begin
                r_esc <= esc;
                r_xy  <= init_val;
            end
            S_UPD: begin
                r_x     <= next_x;
                r_y     <= next_y;
                r_count <= r_count + 1'b1;
            end
            S_DIV: begin
                if (div_done) begin
                    r_norm <= div_quot;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register. A zero maximum ends the loop after the first escape test;
    // its normalized value is one whole for an inside pixel and zero otherwise.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_row         <= r_req.pixel_row;
            r_out.out_col         <= r_req.pixel_col;
            r_out.iteration_count <= 16'(r_count);
            r_out.inside_set      <= !r_esc;
            if (r_max_iter == '0) begin
                r_out.normalized_value <= r_esc ? '0 : NORM_ONE;
            end else begin
                r_out.normalized_value <= r_norm;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // An update step only happens while the count is still below the limit.
    a_upd_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_count < r_max_iter))
        else $error("update step at or past the iteration limit");

    // Each update step bumps the count by one and starts the next squares.
    a_upd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state == S_SQX && r_count == $past(r_count) + 1'b1))
        else $error("iteration count did not advance by one");

    // A pixel that ran to the limit without escaping normalizes to one.
    a_inside_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_esc && r_max_iter != '0) |-> (r_norm == NORM_ONE))
        else $error("inside pixel did not normalize to one");

    // A result only appears out of the hold state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_HOLD))
        else $error("result raised outside the hold state");

endmodule

// ----- hdl/mbe_mul.sv -----
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiplier with a registered product, reused for every square,
// cross product and coordinate scaling of the escape-time loop.
// ----------------------------------------------------------------------------
module mbe_mul (
    input  logic                          i_clk,
    input  logic [mbe_pkg::MUL_W-1:0]     i_a,
    input  logic [mbe_pkg::MUL_W-1:0]     i_b,
    output logic [2*mbe_pkg::MUL_W-1:0]   o_p
);
    import mbe_pkg::*;

    logic [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- hdl/mbe_div.sv -----
// ----------------------------------------------------------------------------
// Normalization divider
// Restoring divider giving floor(count * 2^16 / max), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mbe_div #(
    parameter int ITER_BITS = mbe_pkg::ITER_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ITER_BITS-1:0]            i_count,
    input  logic [ITER_BITS-1:0]            i_max,
    output logic                            o_done,
    output logic [mbe_pkg::NORM_BITS-1:0]   o_quot
);
    import mbe_pkg::*;

    localparam int STEP_W = $clog2(NORM_BITS);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [ITER_BITS:0]    r_rem;
    logic [ITER_BITS-1:0]  r_div;
    logic [NORM_BITS-1:0]  r_quot;

    logic                  q_bit;
    logic [ITER_BITS:0]    rem_sub;
    logic [ITER_BITS-1:0]  rem_keep;

    // With a nonzero divisor and a count not above it, the kept remainder stays below the divisor after each step.
    assign q_bit    = (r_rem >= {1'b0, r_div});
    assign rem_sub  = r_rem - {1'b0, r_div};
    assign rem_keep = q_bit ? rem_sub[ITER_BITS-1:0] : r_rem[ITER_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NORM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_count};
            r_div <= i_max;
        end else if (r_busy) begin
            r_rem  <= {rem_keep, 1'b0};
            r_quot <= {r_quot[NORM_BITS-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    // With a count never above the divisor the quotient cannot pass one whole.
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_div != '0) |-> (o_quot <= NORM_ONE))
        else $error("normalized quotient above one");

endmodule
